FILE: sv/debounced_status_report_scheduler_top_assert.svh
// Assertion macros for the debounced status report scheduler checker.
// Used by dsrs_checker.sv only; no other dependencies.
`ifndef DEBOUNCED_STATUS_REPORT_SCHEDULER_TOP_ASSERT_SVH
`define DEBOUNCED_STATUS_REPORT_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted
`define DSRS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, masked while reset is asserted
`define DSRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication that also holds across reset
`define DSRS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: sv/dsrs_pkg.sv
// Shared types, constants and helpers for the debounced status report scheduler.
// No dependencies; imported by the front, queue, back and top modules.
`default_nettype none

package dsrs_pkg;

    // Ages saturate above the widest threshold, so compares stay exact
    localparam int AGE_W  = 21;
    localparam int TEMP_W = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_STATUS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_REPORT_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_DEADBAND    = 3'd4;

    // Register reset values
    localparam logic        RST_INVERT_STATUS    = 1'b0;
    localparam logic [15:0] RST_DEBOUNCE_TICKS   = 16'd50;
    localparam logic [19:0] RST_MIN_REPORT_TICKS = 20'd1000;
    localparam logic [19:0] RST_PERIODIC_TICKS   = 20'd60000;
    localparam logic [10:0] RST_TEMP_DEADBAND    = 11'd5;

    // Status codes and temperature reset value
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
    localparam logic signed [TEMP_W-1:0] TEMP_RESET = -12'sd1270;

    // Report kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_TEMP   = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic signed [TEMP_W-1:0] value;
    } dsrs_report_t;

    // All reports caused by one tick: one or two
    typedef struct packed {
        logic         two;
        dsrs_report_t first;
        dsrs_report_t second;
    } dsrs_entry_t;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } dsrs_cfg_wr_t;

    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
        return (&a) ? a : a + AGE_W'(1);
    endfunction

endpackage

`default_nettype wire

FILE: sv/dsrs_front.sv
// Front end: configuration registers, debounce and report scheduling state.
// Classifies each tick word into a queue entry of one or two reports. Uses dsrs_pkg.
`default_nettype none

module dsrs_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dsrs_pkg::dsrs_cfg_wr_t        cfg_wr,
    input  wire logic                          tick_accept,
    input  wire logic                          raw_status,
    input  wire logic signed [dsrs_pkg::TEMP_W-1:0] temp_sample,
    input  wire logic                          temp_valid,
    input  wire logic                          restart_timers,
    output logic                               push,
    output dsrs_pkg::dsrs_entry_t              push_entry
);
    import dsrs_pkg::*;

    // Configuration registers
    logic        invert_reg;
    logic [15:0] debounce_reg;
    logic [19:0] min_report_reg;
    logic [19:0] periodic_reg;
    logic [10:0] deadband_reg;

    // Scheduling state
    logic [1:0]               stable_reg, stable_next;
    logic [1:0]               last_raw_reg, last_raw_next;
    logic [1:0]               rep_status_reg, rep_status_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic signed [TEMP_W-1:0] rep_temp_reg, rep_temp_next;
    logic [AGE_W-1:0]         unstable_age_reg, unstable_age_next;
    logic [AGE_W-1:0]         report_age_reg, report_age_next;
    logic                     pick_reg, pick_next;

    logic                     level;
    logic                     imm_fire;
    logic                     gated_fire;
    dsrs_report_t             imm_rep;
    dsrs_report_t             gated_rep;
    logic signed [TEMP_W:0]   temp_diff;
    logic [TEMP_W:0]          temp_dist;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg     <= RST_INVERT_STATUS;
            debounce_reg   <= RST_DEBOUNCE_TICKS;
            min_report_reg <= RST_MIN_REPORT_TICKS;
            periodic_reg   <= RST_PERIODIC_TICKS;
            deadband_reg   <= RST_TEMP_DEADBAND;
        end else if (cfg_wr.valid) begin
            unique case (cfg_wr.index)
                CFG_INVERT_STATUS:    invert_reg     <= cfg_wr.data[0];
                CFG_DEBOUNCE_TICKS:   debounce_reg   <= cfg_wr.data[15:0];
                CFG_MIN_REPORT_TICKS: min_report_reg <= cfg_wr.data;
                CFG_PERIODIC_TICKS:   periodic_reg   <= cfg_wr.data;
                CFG_TEMP_DEADBAND:    deadband_reg   <= cfg_wr.data[10:0];
                default: ;
            endcase
        end
    end

    // Evaluate one tick
    always_comb begin
        level             = raw_status ^ invert_reg;
        unstable_age_next = age_inc(unstable_age_reg);
        report_age_next   = age_inc(report_age_reg);
        if (restart_timers) begin
            unstable_age_next = '0;
            report_age_next   = '0;
        end

        temp_next = temp_valid ? temp_sample : temp_reg;

        // Restart the stable time on any level change
        last_raw_next = last_raw_reg;
        if ({1'b0, level} != last_raw_reg) begin
            unstable_age_next = '0;
            last_raw_next     = {1'b0, level};
        end

        // Accept a debounced level and report it at once
        stable_next     = stable_reg;
        rep_status_next = rep_status_reg;
        imm_fire = (unstable_age_next > AGE_W'(debounce_reg))
                   && (stable_reg != {1'b0, level});
        if (imm_fire) begin
            stable_next     = {1'b0, level};
            rep_status_next = {1'b0, level};
        end
        imm_rep.kind  = KIND_STATUS;
        imm_rep.value = {{(TEMP_W-1){1'b0}}, level};

        // Distance of current temperature from the last one reported
        temp_diff = {temp_next[TEMP_W-1], temp_next}
                    - {rep_temp_reg[TEMP_W-1], rep_temp_reg};
        temp_dist = temp_diff[TEMP_W] ? (TEMP_W+1)'(-temp_diff) : temp_diff;

        // Pick at most one gated report
        rep_temp_next   = rep_temp_reg;
        pick_next       = pick_reg;
        gated_fire      = 1'b0;
        gated_rep.kind  = KIND_STATUS;
        gated_rep.value = {{(TEMP_W-2){1'b0}}, stable_next};
        if (report_age_next > AGE_W'(min_report_reg)) begin
            if (stable_next != rep_status_next) begin
                gated_fire      = 1'b1;
                rep_status_next = stable_next;
            end else if (temp_dist > (TEMP_W+1)'(deadband_reg)) begin
                gated_fire      = 1'b1;
                gated_rep.kind  = KIND_TEMP;
                gated_rep.value = temp_next;
                rep_temp_next   = temp_next;
            end else if (report_age_next > AGE_W'(periodic_reg)) begin
                gated_fire = 1'b1;
                pick_next  = ~pick_reg;
                if (!pick_reg) begin
                    rep_status_next = stable_next;
                end else begin
                    gated_rep.kind  = KIND_TEMP;
                    gated_rep.value = temp_next;
                    rep_temp_next   = temp_next;
                end
            end
            if (gated_fire) begin
                report_age_next = '0;
            end
        end

        // Pack reports of this tick into a queue entry
        push = tick_accept && (imm_fire || gated_fire);
        if (imm_fire) begin
            push_entry.two    = gated_fire;
            push_entry.first  = imm_rep;
            push_entry.second = gated_rep;
        end else begin
            push_entry.two    = 1'b0;
            push_entry.first  = gated_rep;
            push_entry.second = gated_rep;
        end
    end

    // Advance state on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg       <= STATUS_UNKNOWN;
            last_raw_reg     <= STATUS_UNKNOWN;
            rep_status_reg   <= STATUS_UNKNOWN;
            temp_reg         <= TEMP_RESET;
            rep_temp_reg     <= TEMP_RESET;
            unstable_age_reg <= '0;
            report_age_reg   <= '0;
            pick_reg         <= 1'b0;
        end else if (tick_accept) begin
            stable_reg       <= stable_next;
            last_raw_reg     <= last_raw_next;
            rep_status_reg   <= rep_status_next;
            temp_reg         <= temp_next;
            rep_temp_reg     <= rep_temp_next;
            unstable_age_reg <= unstable_age_next;
            report_age_reg   <= report_age_next;
            pick_reg         <= pick_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/dsrs_queue.sv
// Short FIFO of per-tick report entries between front and back ends.
// Register based; uses dsrs_pkg for the entry type.
`default_nettype none

module dsrs_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire dsrs_pkg::dsrs_entry_t push_entry,
    input  wire logic                  pop,
    output dsrs_pkg::dsrs_entry_t      head,
    output logic                       full,
    output logic                       empty
);
    import dsrs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    dsrs_entry_t       slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots[rd_ptr_reg];

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/dsrs_back.sv
// Back end: unpacks queue entries into single report words on the output stream.
// Output register plus a held second report; uses dsrs_pkg.
`default_nettype none

module dsrs_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dsrs_pkg::dsrs_entry_t head,
    input  wire logic                  empty,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);
    import dsrs_pkg::*;

    logic         valid_reg;
    logic         second_pend_reg;
    logic         last_reg;
    dsrs_report_t out_reg;
    dsrs_report_t second_reg;
    logic         handshake;

    assign handshake = valid_reg && m_tready;
    assign pop       = !second_pend_reg && (!valid_reg || handshake) && !empty;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(16-TEMP_W){1'b0}}, out_reg.value};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = last_reg;

    // Track output valid and the held second report
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            second_pend_reg <= 1'b0;
        end else if (handshake && second_pend_reg) begin
            second_pend_reg <= 1'b0;
        end else if (pop) begin
            valid_reg       <= 1'b1;
            second_pend_reg <= head.two;
        end else if (handshake) begin
            valid_reg <= 1'b0;
        end
    end

    // Load the output word and hold the second report
    always_ff @(posedge aclk) begin
        if (handshake && second_pend_reg) begin
            out_reg  <= second_reg;
            last_reg <= 1'b1;
        end else if (pop) begin
            out_reg    <= head.first;
            last_reg   <= !head.two;
            second_reg <= head.second;
        end
    end

endmodule

`default_nettype wire

FILE: sv/debounced_status_report_scheduler_top.sv
// Top level of the debounced status report scheduler.
// Instantiates dsrs_front, dsrs_queue and dsrs_back; uses dsrs_pkg.
//
//   channel   direction  handshake            payload
//   s_        in         s_tvalid / s_tready  tick word: status, temperature, restart
//   m_        out        m_tvalid / m_tready  report word: kind, value, last
//   cfg_      in         cfg_valid/cfg_ready  register index and write data
//
// One tick word is taken per cycle while the entry queue has room; the front end
// settles a tick in the cycle it is accepted. Each tick yields zero, one or two
// report words, and the output register moves one word per cycle while m_tready
// is high, so the two reports of a tick leave back to back. s_tready drops only
// when all QUEUE_DEPTH queue entries are in use. Synchronous active-low reset
// restores register defaults and clears the queue; cfg_ready is always high.
`default_nettype none

module debounced_status_report_scheduler_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Tick input
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [15:0]                     s_tdata,   // raw_status, temp_sample, restart_timers
    input  wire logic                            s_tuser,   // temp_valid
    // Report output
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [15:0]                          m_tdata,   // report_value
    output logic                                 m_tuser,   // report_kind
    output logic                                 m_tlast,
    // Configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dsrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dsrs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dsrs_pkg::*;

    dsrs_cfg_wr_t cfg_wr;
    dsrs_entry_t  push_entry;
    dsrs_entry_t  head;
    logic         tick_accept;
    logic         push;
    logic         pop;
    logic         full;
    logic         empty;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    assign s_tready    = !full;
    assign tick_accept = s_tvalid && !full;

    dsrs_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr         (cfg_wr),
        .tick_accept    (tick_accept),
        .raw_status     (s_tdata[0]),
        .temp_sample    (s_tdata[TEMP_W:1]),
        .temp_valid     (s_tuser),
        .restart_timers (s_tdata[TEMP_W+1]),
        .push           (push),
        .push_entry     (push_entry)
    );

    dsrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    dsrs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: sv/dsrs_checker.sv
// Port-level checks for the debounced status report scheduler, bound to the top.
// Uses the macros in debounced_status_report_scheduler_top_assert.svh.
`default_nettype none

`include "debounced_status_report_scheduler_top_assert.svh"

module dsrs_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        m_tlast
);

    // Stalled report word holds
    `DSRS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // Second report of a tick follows right after the first is taken
    `DSRS_ASSERT_NEXT(a_pair_back_to_back, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast)

    // Status reports carry only 0, 1 or unknown
    `DSRS_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[15:2] == 14'd0 && m_tdata[1:0] != 2'd3)

    // Reset empties the output register
    `DSRS_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_tvalid)

endmodule

bind debounced_status_report_scheduler_top dsrs_checker u_dsrs_checker (.*);

`default_nettype wire
